// ===== design/packed_exponent_field_unpacker_defines.svh =====
// ----------------------------------------------------------------------------
// Packed exponent field unpacker: assertion macros
// Shared property wrappers for the unpacker's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PACKED_EXPONENT_FIELD_UNPACKER_DEFINES_SVH
`define PACKED_EXPONENT_FIELD_UNPACKER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PEFU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pefu check failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define PEFU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pefu check failed: next-cycle implication");

`endif

// ===== design/pefu_pkg.sv =====
// ----------------------------------------------------------------------------
// Packed exponent field unpacker package
// Shared widths, register indexes and the control structs between modules.
// ----------------------------------------------------------------------------
package pefu_pkg;

   localparam int FIELD_W   = 64;  // result value width
   localparam int POS_W     = 6;   // field_position width
   localparam int FB_W      = 7;   // field_bits register width
   localparam int WW_W      = 4;   // wide_words register width
   localparam int FPE_W     = 7;   // fields_per_entry register width
   localparam int SKIP_W    = 3;   // high-word skip counter width
   localparam int SH_W      = 8;   // bit offset plus two field widths
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIELD_BITS       = 2'd0,
      CSR_WIDE_WORDS       = 2'd1,
      CSR_FIELDS_PER_ENTRY = 2'd2,
      CSR_UNUSED           = 2'd3
   } csr_index_type;

   // Effective configuration, already clamped to legal ranges.
   typedef struct packed {
      logic [FB_W-1:0]   fb;      // field width, 1..WORD_BITS
      logic              wide;    // more than one word per field
      logic [SKIP_W-1:0] skip;    // high words following a wide field's low word
      logic [FPE_W-1:0]  fpe;     // fields per entry, at least 1
   } cfg_type;

   // Sequencer commands to the shift unit.
   typedef struct packed {
      logic load;
      logic step;
   } slice_ctl_type;

endpackage

// ===== design/pefu_csr.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds field_bits, wide_words and fields_per_entry and clamps them.
// ----------------------------------------------------------------------------
module pefu_csr #(
   parameter int WORD_BITS      = 64,
   parameter int MAX_FIELDS     = 64,
   parameter int MAX_WIDE_WORDS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [pefu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pefu_pkg::CSR_DAT_W-1:0]     csr_wdata,
   output pefu_pkg::cfg_type                  cfg
);

   localparam logic [6:0] WORD_BITS_C = 7'(WORD_BITS);
   localparam logic [6:0] MAX_WW_C    = 7'(MAX_WIDE_WORDS);
   localparam logic [8:0] MAX_FPE_C   = 9'(MAX_FIELDS);

   logic [pefu_pkg::FB_W-1:0]  field_bits_ff, field_bits_in;
   logic [pefu_pkg::WW_W-1:0]  wide_words_ff, wide_words_in;
   logic [pefu_pkg::FPE_W-1:0] fpe_ff, fpe_in;
   logic [6:0]                 ww_ext;
   logic [6:0]                 ww_eff;
   logic [8:0]                 fpe_ext;

   always_comb begin
      field_bits_in = field_bits_ff;
      wide_words_in = wide_words_ff;
      fpe_in        = fpe_ff;
      if (csr_valid) begin
         case (pefu_pkg::csr_index_type'(csr_index))
            pefu_pkg::CSR_FIELD_BITS:       field_bits_in = csr_wdata;
            pefu_pkg::CSR_WIDE_WORDS:       wide_words_in = csr_wdata[pefu_pkg::WW_W-1:0];
            pefu_pkg::CSR_FIELDS_PER_ENTRY: fpe_in        = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_bits_ff <= 7'd8;
         wide_words_ff <= 4'd1;
         fpe_ff        <= 7'd1;
      end else begin
         field_bits_ff <= field_bits_in;
         wide_words_ff <= wide_words_in;
         fpe_ff        <= fpe_in;
      end
   end

   always_comb begin
      ww_ext  = {3'b000, wide_words_ff};
      fpe_ext = {2'b00, fpe_ff};

      if (field_bits_ff == '0)
         cfg.fb = 7'd1;
      else if (field_bits_ff > WORD_BITS_C)
         cfg.fb = WORD_BITS_C;
      else
         cfg.fb = field_bits_ff;

      if (ww_ext == '0)
         ww_eff = 7'd1;
      else if (ww_ext > MAX_WW_C)
         ww_eff = MAX_WW_C;
      else
         ww_eff = ww_ext;
      cfg.wide = (ww_eff > 7'd1);
      cfg.skip = 3'(ww_eff - 7'd1);

      if (fpe_ext == '0)
         cfg.fpe = 7'd1;
      else if (fpe_ext > MAX_FPE_C)
         cfg.fpe = 7'(MAX_FPE_C);
      else
         cfg.fpe = fpe_ff;
   end

endmodule

// ===== design/pefu_slicer.sv =====
// ----------------------------------------------------------------------------
// Field slicer
// Shared shift unit: holds the word and drops one field off the bottom a step.
// ----------------------------------------------------------------------------
module pefu_slicer #(
   parameter int WORD_BITS = 64
) (
   input  logic                             clock,
   input  pefu_pkg::slice_ctl_type          ctl,
   input  logic [WORD_BITS-1:0]             word,
   input  logic [pefu_pkg::FB_W-1:0]        fb,
   output logic [WORD_BITS-1:0]             whole_word,
   output logic [WORD_BITS-1:0]             field,
   output logic                             fits_next
);

   localparam logic [pefu_pkg::SH_W-1:0] WORD_BITS_C = pefu_pkg::SH_W'(WORD_BITS);

   logic [WORD_BITS-1:0]        word_ff, word_in;
   logic [pefu_pkg::SH_W-1:0]   sh_ff, sh_in;
   logic [WORD_BITS-1:0]        mask;
   logic [pefu_pkg::SH_W-1:0]   next_end;

   always_comb begin
      word_in = word_ff;
      sh_in   = sh_ff;
      if (ctl.load) begin
         word_in = word;
         sh_in   = '0;
      end else if (ctl.step) begin
         word_in = word_ff >> fb;
         sh_in   = sh_ff + {1'b0, fb};
      end
   end

   // Payload only; the sequencer loads before any use.
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      sh_ff   <= sh_in;
   end

   always_comb begin
      if ({1'b0, fb} >= WORD_BITS_C)
         mask = '1;
      else
         mask = (WORD_BITS'(1) << fb) - WORD_BITS'(1);
      field      = word_ff & mask;
      whole_word = word_ff;
      // end bit of the field after this one
      next_end   = sh_ff + {fb, 1'b0};
      fits_next  = (next_end <= WORD_BITS_C);
   end

endmodule

// ===== design/packed_exponent_field_unpacker.sv =====
// ----------------------------------------------------------------------------
// Packed exponent field unpacker
// Splits packed words into fields, one result per field, low bits first.
// ----------------------------------------------------------------------------
// channel  ports                             direction
// req      req_valid/req_stall + payload     in:  packed word, last flag
// rsp      rsp_valid/rsp_stall + payload     out: one field per item
// csr      csr_valid/csr_ready + index/data  in:  register writes
//
// A word is accepted in idle; req_stall then holds off the next word while
// the shared shifter emits its fields, one field per cycle unless rsp stalls.
// A skipped high word of a wide field yields no result. Rsp stall holds the
// output register and the sequencer with it. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
`include "packed_exponent_field_unpacker_defines.svh"

module packed_exponent_field_unpacker #(
   parameter int WORD_BITS      = 64,
   parameter int MAX_FIELDS     = 64,
   parameter int MAX_WIDE_WORDS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [63:0]                          req_packed_word,
   input  logic                                 req_last_in_vector,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [pefu_pkg::FIELD_W-1:0]         rsp_field_value,
   output logic [pefu_pkg::POS_W-1:0]           rsp_field_position,
   output logic                                 rsp_entry_end,
   output logic                                 rsp_vector_end,
   output logic                                 rsp_run_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pefu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pefu_pkg::CSR_DAT_W-1:0]       csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type                         state_ff, state_in;
   logic [pefu_pkg::FPE_W-1:0]        pos_ff, pos_in;
   logic [pefu_pkg::SKIP_W-1:0]       skip_ff, skip_in;
   logic                              last_ff, last_in;
   logic                              wide_ff, wide_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pefu_pkg::FIELD_W-1:0]      value_ff, value_in;
   logic [pefu_pkg::POS_W-1:0]        opos_ff, opos_in;
   logic                              ee_ff, ee_in;
   logic                              ve_ff, ve_in;
   logic                              rl_ff, rl_in;

   pefu_pkg::cfg_type                 cfg;
   pefu_pkg::slice_ctl_type           sctl;
   logic [WORD_BITS-1:0]              whole_word;
   logic [WORD_BITS-1:0]              field;
   logic                              fits_next;

   logic                              req_take;
   logic                              out_free;
   logic                              ee;
   logic                              rl;
   logic [pefu_pkg::FPE_W-1:0]        fpe_last;

   assign csr_ready = 1'b1;

   pefu_csr #(
      .WORD_BITS      (WORD_BITS),
      .MAX_FIELDS     (MAX_FIELDS),
      .MAX_WIDE_WORDS (MAX_WIDE_WORDS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pefu_slicer #(
      .WORD_BITS (WORD_BITS)
   ) u_slicer (
      .clock      (clock),
      .ctl        (sctl),
      .word       (req_packed_word[WORD_BITS-1:0]),
      .fb         (cfg.fb),
      .whole_word (whole_word),
      .field      (field),
      .fits_next  (fits_next)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fpe_last  = cfg.fpe - 7'd1;
   assign ee        = (pos_ff == fpe_last);
   // last field of this word: wide field, end of entry, or next field won't fit
   assign rl        = wide_ff || ee || !fits_next;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      skip_in      = skip_ff;
      last_in      = last_ff;
      wide_in      = wide_ff;
      sctl.load    = 1'b0;
      sctl.step    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      value_in     = value_ff;
      opos_in      = opos_ff;
      ee_in        = ee_ff;
      ve_in        = ve_ff;
      rl_in        = rl_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (skip_ff != '0) begin
                  // high word of a wide field: consumed without a result
                  skip_in = req_last_in_vector ? '0 : skip_ff - 3'd1;
                  if (req_last_in_vector)
                     pos_in = '0;
               end else begin
                  pos_in    = (pos_ff >= cfg.fpe) ? '0 : pos_ff;
                  last_in   = req_last_in_vector;
                  wide_in   = cfg.wide;
                  skip_in   = (cfg.wide && !req_last_in_vector) ? cfg.skip : '0;
                  sctl.load = 1'b1;
                  state_in  = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               value_in     = wide_ff ? pefu_pkg::FIELD_W'(whole_word)
                                      : pefu_pkg::FIELD_W'(field);
               opos_in      = pos_ff[pefu_pkg::POS_W-1:0];
               ee_in        = ee;
               ve_in        = last_ff && rl;
               rl_in        = rl;
               if (rl) begin
                  pos_in   = (ee || last_ff) ? '0 : pos_ff + 7'd1;
                  state_in = ST_IDLE;
               end else begin
                  pos_in    = pos_ff + 7'd1;
                  sctl.step = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         skip_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff  <= last_in;
      wide_ff  <= wide_in;
      value_ff <= value_in;
      opos_ff  <= opos_in;
      ee_ff    <= ee_in;
      ve_ff    <= ve_in;
      rl_ff    <= rl_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_field_value    = value_ff;
   assign rsp_field_position = opos_ff;
   assign rsp_entry_end      = ee_ff;
   assign rsp_vector_end     = ve_ff;
   assign rsp_run_last       = rl_ff;

   `PEFU_ASSERT_IMPLY(a_vend_is_run_last, clock, reset, rsp_valid && rsp_vector_end, rsp_run_last)
   `PEFU_ASSERT_IMPLY(a_run_pos_in_entry, clock, reset, state_ff == ST_RUN, pos_ff < cfg.fpe)
   `PEFU_ASSERT_IMPLY(a_eend_at_last_pos, clock, reset, rsp_valid && rsp_entry_end && state_ff == ST_RUN, rsp_field_position == fpe_last[pefu_pkg::POS_W-1:0] || wide_ff)
   `PEFU_ASSERT_NEXT(a_last_clears_skip, clock, reset, req_take && req_last_in_vector, skip_ff == '0)

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed exponent field unpacker testbench
// Drives packed words through the unpacker under random sender gaps and
// receiver stalls, predicts field items from a local model of the unpacking
// rules or takes them from the checked directed rows, and checks each item field by field, in order.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SETTLE_CYCLES = 16;
   localparam int N_DIRECTED    = 39;

   typedef struct packed {
      logic [63:0] value;
      logic [5:0]  position;
      logic        entry_end;
      logic        vector_end;
      logic        run_last;
   } field_result_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_WORD, ROW_CHECKED} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      pefu_pkg::csr_index_type reg_sel;
      logic [6:0]              reg_val;
      logic [63:0]             word;
      logic                    is_last;
      logic [63:0]             exp_value;
      logic [5:0]              exp_pos;
      logic                    exp_entry_end;
   } dir_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [63:0]                    req_packed_word = '0;
   logic                           req_last_in_vector = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [pefu_pkg::FIELD_W-1:0]   rsp_field_value;
   logic [pefu_pkg::POS_W-1:0]     rsp_field_position;
   logic                           rsp_entry_end;
   logic                           rsp_vector_end;
   logic                           rsp_run_last;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [pefu_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pefu_pkg::CSR_DAT_W-1:0] csr_wdata = '0;

   // predictor copy of the registers and the unpacking state
   logic [6:0] cfg_field_bits = 7'd8;
   logic [3:0] cfg_wide_words = 4'd1;
   logic [6:0] cfg_fields_per_entry = 7'd1;
   int         entry_index = 0;
   int         skip_words = 0;

   field_result_type expected_fields[$];
   dir_row_type      directed_rows [N_DIRECTED];
   int               mismatches = 0;
   int               cycle_count = 0;
   int               stall_left = 0;
   bit               gaps_on = 1'b1;
   bit               stall_on = 1'b1;

   packed_exponent_field_unpacker dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_packed_word    (req_packed_word),
      .req_last_in_vector (req_last_in_vector),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_field_value    (rsp_field_value),
      .rsp_field_position (rsp_field_position),
      .rsp_entry_end      (rsp_entry_end),
      .rsp_vector_end     (rsp_vector_end),
      .rsp_run_last       (rsp_run_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Splits one accepted word into the field items it should produce.
   function automatic void predict_word(input logic [63:0] word, input logic is_last,
                                        input bit record);
      int               fb;
      int               ww;
      int               fpe;
      int               per;
      int               cnt;
      logic [63:0]      mask;
      field_result_type r;
      fb  = (cfg_field_bits == 0) ? 1 : (cfg_field_bits > 64) ? 64 : int'(cfg_field_bits);
      ww  = (cfg_wide_words == 0) ? 1 : (cfg_wide_words > 8) ? 8 : int'(cfg_wide_words);
      fpe = (cfg_fields_per_entry == 0) ? 1 :
            (cfg_fields_per_entry > 64) ? 64 : int'(cfg_fields_per_entry);
      // high words of a wide field: consumed, nothing emitted
      if (skip_words != 0) begin
         skip_words--;
         if (is_last) begin
            entry_index = 0;
            skip_words = 0;
         end
         return;
      end
      if (entry_index >= fpe)
         entry_index = 0;
      if (ww > 1) begin
         r.value      = word;
         r.position   = 6'(entry_index);
         r.entry_end  = (entry_index == fpe - 1);
         r.vector_end = is_last;
         r.run_last   = 1'b1;
         if (record)
            expected_fields.push_back(r);
         entry_index = r.entry_end ? 0 : entry_index + 1;
         skip_words = ww - 1;
      end else begin
         mask = (fb == 64) ? '1 : (64'd1 << fb) - 64'd1;
         per = 64 / fb;
         cnt = (per < fpe - entry_index) ? per : fpe - entry_index;
         for (int k = 0; k < cnt; k++) begin
            r.value      = (word >> (k * fb)) & mask;
            r.position   = 6'(entry_index + k);
            r.entry_end  = (entry_index + k == fpe - 1);
            r.run_last   = (k == cnt - 1);
            r.vector_end = is_last && r.run_last;
            if (record)
               expected_fields.push_back(r);
         end
         entry_index += cnt;
         if (entry_index >= fpe)
            entry_index = 0;
      end
      if (is_last) begin
         entry_index = 0;
         skip_words = 0;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      if (!gaps_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   task automatic send_word(input logic [63:0] word, input logic is_last, input bit checked,
                            input field_result_type typed);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_packed_word <= word;
      req_last_in_vector <= is_last;
      do @(posedge clock); while (req_stall);
      predict_word(word, is_last, !checked);
      if (checked)
         expected_fields.push_back(typed);
   endtask

   // caller lowers csr_valid once the batch of writes is done
   task automatic write_reg(input pefu_pkg::csr_index_type sel, input logic [6:0] val);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (sel)
         pefu_pkg::CSR_FIELD_BITS:       cfg_field_bits = val;
         pefu_pkg::CSR_WIDE_WORDS:       cfg_wide_words = val[3:0];
         pefu_pkg::CSR_FIELDS_PER_ENTRY: cfg_fields_per_entry = val;
         default: ;
      endcase
   endtask

   // skipped high words produce no item, so the task still waits after the queue drains
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_fields.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_on && $urandom_range(0, 99) < 20) begin
         rsp_stall <= 1'b1;
         stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) :
                                                      $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_fields
      field_result_type got;
      field_result_type want;
      got = '{rsp_field_value, rsp_field_position, rsp_entry_end, rsp_vector_end,
              rsp_run_last};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_fields.size() == 0) begin
            mismatches++;
            if (mismatches < 40)
               $display("%0t: unexpected field item value %h pos %0d", $time,
                        got.value, got.position);
         end else begin
            want = expected_fields.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches < 40)
                  $display({"%0t: field mismatch: expected value %h pos %0d ee %b ve %b rl %b,",
                            " got value %h pos %0d ee %b ve %b rl %b"}, $time,
                           want.value, want.position, want.entry_end, want.vector_end,
                           want.run_last, got.value, got.position, got.entry_end,
                           got.vector_end, got.run_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("packed_exponent_field_unpacker test failed");
         $finish;
      end
   end

   initial begin
      int               left;
      int               vec_len;
      int               r;
      logic [63:0]      word;
      logic             is_last;
      logic [6:0]       fb_val;
      logic [6:0]       ww_val;
      logic [6:0]       fpe_val;
      field_result_type typed;
      dir_row_type      row;

      directed_rows = '{
         // reset config: 8-bit fields, one field per entry
         '{ROW_CHECKED, pefu_pkg::CSR_UNUSED, 7'd0, 64'h0123_4567_89AB_CDEF, 1'b0,
           64'hEF, 6'd0, 1'b1},
         '{ROW_CHECKED, pefu_pkg::CSR_UNUSED, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
           64'hFF, 6'd0, 1'b1},
         '{ROW_CHECKED, pefu_pkg::CSR_UNUSED, 7'd0, 64'h0, 1'b0, 64'h0, 6'd0, 1'b1},
         '{ROW_CSR, pefu_pkg::CSR_UNUSED, 7'h7F, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
         '{ROW_CHECKED, pefu_pkg::CSR_UNUSED, 7'd0, 64'h8000_0000_0000_0081, 1'b1,
           64'h81, 6'd0, 1'b1},
         // zero width acts as 1, oversized entry clamps to 64
         '{ROW_CSR, pefu_pkg::CSR_FIELD_BITS, 7'd0, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
         '{ROW_CSR, pefu_pkg::CSR_FIELDS_PER_ENTRY, 7'h7F, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
         '{ROW_WORD, pefu_pkg::CSR_UNUSED, 7'd0, 64'hA5A5_5A5A_F00F_0FF0, 1'b1,
           64'h0, 6'd0, 1'b0},
         // oversized width acts as a full word, zero entry size acts as 1
         '{ROW_CSR, pefu_pkg::CSR_FIELD_BITS, 7'h7F, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
         '{ROW_CSR, pefu_pkg::CSR_FIELDS_PER_ENTRY, 7'd0, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
         '{ROW_CHECKED, pefu_pkg::CSR_UNUSED, 7'd0, 64'hFFFF_0000_1234_5678, 1'b1,
           64'hFFFF_0000_1234_5678, 6'd0, 1'b1},
         '{ROW_CHECKED, pefu_pkg::CSR_UNUSED, 7'd0, 64'h8000_0000_0000_0000, 1'b0,
           64'h8000_0000_0000_0000, 6'd0, 1'b1},
         // 7-bit fields, 20 per entry: 9 + 9 + 2
         '{ROW_CSR, pefu_pkg::CSR_FIELD_BITS, 7'd7, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
         '{ROW_CSR, pefu_pkg::CSR_FIELDS_PER_ENTRY, 7'd20, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
         '{ROW_WORD, pefu_pkg::CSR_UNUSED, 7'd0, 64'h1357_9BDF_2468_ACE0, 1'b0,
           64'h0, 6'd0, 1'b0},
         '{ROW_WORD, pefu_pkg::CSR_UNUSED, 7'd0, 64'hFEDC_BA98_7654_3210, 1'b0,
           64'h0, 6'd0, 1'b0},
         '{ROW_WORD, pefu_pkg::CSR_UNUSED, 7'd0, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0,
           64'h0, 6'd0, 1'b0},
         '{ROW_WORD, pefu_pkg::CSR_UNUSED, 7'd0, 64'h3C3C_3C3C_3C3C_3C3C, 1'b0,
           64'h0, 6'd0, 1'b0},
         // shrinking the entry below the current index restarts it
         '{ROW_CSR, pefu_pkg::CSR_FIELDS_PER_ENTRY, 7'd5, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
         '{ROW_WORD, pefu_pkg::CSR_UNUSED, 7'd0, 64'hC3C3_C3C3_C3C3_C3C3, 1'b0,
           64'h0, 6'd0, 1'b0},
         // entries cut short by the end of the vector
         '{ROW_CSR, pefu_pkg::CSR_FIELDS_PER_ENTRY, 7'd12, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
         '{ROW_WORD, pefu_pkg::CSR_UNUSED, 7'd0, 64'h5555_AAAA_5555_AAAA, 1'b1,
           64'h0, 6'd0, 1'b0},
         '{ROW_WORD, pefu_pkg::CSR_UNUSED, 7'd0, 64'hAAAA_5555_AAAA_5555, 1'b1,
           64'h0, 6'd0, 1'b0},
         // wide mode, three words per field
         '{ROW_CSR, pefu_pkg::CSR_WIDE_WORDS, 7'd3, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
         '{ROW_CHECKED, pefu_pkg::CSR_UNUSED, 7'd0, 64'hDEAD_BEEF_CAFE_F00D, 1'b0,
           64'hDEAD_BEEF_CAFE_F00D, 6'd0, 1'b0},
         '{ROW_WORD, pefu_pkg::CSR_UNUSED, 7'd0, 64'h1111_1111_1111_1111, 1'b0,
           64'h0, 6'd0, 1'b0},
         '{ROW_WORD, pefu_pkg::CSR_UNUSED, 7'd0, 64'h2222_2222_2222_2222, 1'b0,
           64'h0, 6'd0, 1'b0},
         '{ROW_CHECKED, pefu_pkg::CSR_UNUSED, 7'd0, 64'h0BAD_F00D_0000_0001, 1'b0,
           64'h0BAD_F00D_0000_0001, 6'd1, 1'b0},
         // final word lands on a skipped high word: no item at all
         '{ROW_WORD, pefu_pkg::CSR_UNUSED, 7'd0, 64'h3333_3333_3333_3333, 1'b1,
           64'h0, 6'd0, 1'b0},
         '{ROW_CHECKED, pefu_pkg::CSR_UNUSED, 7'd0, 64'h7777_7777_7777_7777, 1'b0,
           64'h7777_7777_7777_7777, 6'd0, 1'b0},
         // oversized wide count clamps to 8; pending skips carry over
         '{ROW_CSR, pefu_pkg::CSR_WIDE_WORDS, 7'd15, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
         '{ROW_WORD, pefu_pkg::CSR_UNUSED, 7'd0, 64'h4444_4444_4444_4444, 1'b0,
           64'h0, 6'd0, 1'b0},
         '{ROW_WORD, pefu_pkg::CSR_UNUSED, 7'd0, 64'h6666_6666_6666_6666, 1'b0,
           64'h0, 6'd0, 1'b0},
         '{ROW_CHECKED, pefu_pkg::CSR_UNUSED, 7'd0, 64'h1234_5678_9ABC_DEF0, 1'b0,
           64'h1234_5678_9ABC_DEF0, 6'd1, 1'b0},
         '{ROW_WORD, pefu_pkg::CSR_UNUSED, 7'd0, 64'h8888_8888_8888_8888, 1'b1,
           64'h0, 6'd0, 1'b0},
         // zero wide count is narrow mode
         '{ROW_CSR, pefu_pkg::CSR_WIDE_WORDS, 7'd0, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
         '{ROW_CSR, pefu_pkg::CSR_FIELDS_PER_ENTRY, 7'd2, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
         '{ROW_CSR, pefu_pkg::CSR_FIELD_BITS, 7'd32, 64'h0, 1'b0, 64'h0, 6'd0, 1'b0},
         '{ROW_WORD, pefu_pkg::CSR_UNUSED, 7'd0, 64'h9999_9999_9999_9999, 1'b1,
           64'h0, 6'd0, 1'b0}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            if (i == 0 || directed_rows[i-1].kind != ROW_CSR)
               wait_idle();
            write_reg(row.reg_sel, row.reg_val);
            if (i == N_DIRECTED - 1 || directed_rows[i+1].kind != ROW_CSR)
               csr_valid <= 1'b0;
         end else begin
            typed = '{row.exp_value, row.exp_pos, row.exp_entry_end, row.is_last, 1'b1};
            send_word(row.word, row.is_last, row.kind == ROW_CHECKED, typed);
         end
      end

      typed = '0;
      for (int phase = 0; phase < 7; phase++) begin
         wait_idle();
         r = $urandom_range(0, 9);
         fb_val = (r == 0) ? 7'd0 : (r == 1) ? 7'd1 : (r == 2) ? 7'd64 :
                  (r == 3) ? 7'($urandom_range(65, 127)) :
                  (r < 7) ? 7'($urandom_range(2, 12)) : 7'($urandom_range(13, 63));
         r = $urandom_range(0, 9);
         ww_val = (r < 6) ? 7'd1 : (r == 6) ? 7'd0 :
                  (r < 9) ? 7'($urandom_range(2, 8)) : 7'($urandom_range(9, 127));
         r = $urandom_range(0, 9);
         fpe_val = (r == 0) ? 7'd0 : (r == 1) ? 7'($urandom_range(65, 127)) :
                   (r == 2) ? 7'd64 : (r < 7) ? 7'($urandom_range(1, 8)) :
                   7'($urandom_range(9, 40));
         write_reg(pefu_pkg::CSR_FIELD_BITS, fb_val);
         write_reg(pefu_pkg::CSR_WIDE_WORDS, ww_val);
         write_reg(pefu_pkg::CSR_FIELDS_PER_ENTRY, fpe_val);
         if ($urandom_range(0, 3) == 0)
            write_reg(pefu_pkg::CSR_UNUSED, 7'($urandom_range(0, 127)));
         csr_valid <= 1'b0;
         gaps_on = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);

         // mostly whole vectors; an occasional flipped end flag splits one or joins two
         left = $urandom_range(10, 14);
         while (left > 0) begin
            vec_len = $urandom_range(1, 6);
            if (vec_len > left)
               vec_len = left;
            for (int j = 0; j < vec_len; j++) begin
               is_last = (j == vec_len - 1);
               if ($urandom_range(0, 9) == 0)
                  is_last = ~is_last;
               r = $urandom_range(0, 9);
               word = (r == 0) ? 64'h0 : (r == 1) ? '1 : {$urandom(), $urandom()};
               send_word(word, is_last, 1'b0, typed);
            end
            left -= vec_len;
         end
      end

      wait_idle();
      if (mismatches == 0 && expected_fields.size() == 0)
         $display("packed_exponent_field_unpacker test passed");
      else
         $display("packed_exponent_field_unpacker test failed");
      $finish;
   end

endmodule
